>>> rtl/core/canhb_pkg.sv
// Package for the CAN identifier router with heartbeat watchdog.
// Identifier bases, class codes, request codes and default sizes.
// No dependencies.
package canhb_pkg;

  // Default sizes
  localparam int unsigned DEVICE_COUNT_DEF   = 4;
  localparam int unsigned THRUSTER_COUNT_DEF = 6;
  localparam int unsigned ARM_COUNT_DEF      = 4;

  // At most this many lost words per check
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int unsigned ID_W    = 29;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned UNIT_W  = 3;

  localparam logic [ID_W-1:0] ID_HEARTBEAT   = 29'h200;
  localparam logic [ID_W-1:0] ID_THR_CURRENT = 29'h300;
  localparam logic [ID_W-1:0] ID_THR_PWM     = 29'h310;
  localparam logic [ID_W-1:0] ID_IMU         = 29'h400;
  localparam logic [ID_W-1:0] ID_ARM         = 29'h500;
  localparam logic [ID_W-1:0] ID_DEPTH       = 29'h600;
  localparam logic [ID_W-1:0] ID_INDICATOR   = 29'h700;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef enum logic [CLASS_W-1:0] {
    CLS_HEARTBEAT   = 4'd0,
    CLS_THR_CURRENT = 4'd1,
    CLS_THR_PWM     = 4'd2,
    CLS_IMU         = 4'd3,
    CLS_ARM         = 4'd4,
    CLS_DEPTH       = 4'd5,
    CLS_INDICATOR   = 4'd6,
    CLS_UNKNOWN     = 4'd7,
    CLS_LOST        = 4'd8
  } msg_class_e;

  // Classifier verdict handed to the sequencer
  typedef struct packed {
    msg_class_e        cls;
    logic [UNIT_W-1:0] unit;
    logic              hb_hit;
  } class_res_t;

endpackage

>>> rtl/core/canhb_classify.sv
// Identifier classifier: sorts a 29-bit CAN id into a message class and unit.
// Combinational. Depends on canhb_pkg.
module canhb_classify import canhb_pkg::*; #(
  parameter int unsigned DEVICE_COUNT   = DEVICE_COUNT_DEF,
  parameter int unsigned THRUSTER_COUNT = THRUSTER_COUNT_DEF,
  parameter int unsigned ARM_COUNT      = ARM_COUNT_DEF,
  parameter int unsigned IDX_W          = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1
) (
  input  logic [ID_W-1:0]  frame_id_i,
  output class_res_t       res_o,
  output logic [IDX_W-1:0] hb_dev_o
);

  logic [ID_W-1:0] d_hb, d_cur, d_pwm, d_arm;
  logic            in_hb, in_cur, in_pwm, in_arm;

  assign d_hb  = frame_id_i - ID_HEARTBEAT;
  assign d_cur = frame_id_i - ID_THR_CURRENT;
  assign d_pwm = frame_id_i - ID_THR_PWM;
  assign d_arm = frame_id_i - ID_ARM;

  assign in_hb  = (frame_id_i >= ID_HEARTBEAT)   && (d_hb  < ID_W'(DEVICE_COUNT));
  assign in_cur = (frame_id_i >= ID_THR_CURRENT) && (d_cur < ID_W'(THRUSTER_COUNT));
  assign in_pwm = (frame_id_i >= ID_THR_PWM)     && (d_pwm < ID_W'(THRUSTER_COUNT));
  assign in_arm = (frame_id_i >= ID_ARM)         && (d_arm < ID_W'(ARM_COUNT));

  assign hb_dev_o = d_hb[IDX_W-1:0];

  // first match wins, in the order listed
  always_comb begin
    res_o.hb_hit = 1'b0;
    res_o.unit   = '0;
    if (in_hb) begin
      res_o.cls    = CLS_HEARTBEAT;
      res_o.unit   = d_hb[UNIT_W-1:0];
      res_o.hb_hit = 1'b1;
    end else if (in_cur) begin
      res_o.cls  = CLS_THR_CURRENT;
      res_o.unit = d_cur[UNIT_W-1:0];
    end else if (in_pwm) begin
      res_o.cls  = CLS_THR_PWM;
      res_o.unit = d_pwm[UNIT_W-1:0];
    end else if (frame_id_i == ID_IMU) begin
      res_o.cls = CLS_IMU;
    end else if (in_arm) begin
      res_o.cls  = CLS_ARM;
      res_o.unit = d_arm[UNIT_W-1:0];
    end else if (frame_id_i == ID_DEPTH) begin
      res_o.cls = CLS_DEPTH;
    end else if (frame_id_i == ID_INDICATOR) begin
      res_o.cls = CLS_INDICATOR;
    end else begin
      res_o.cls = CLS_UNKNOWN;
    end
  end

endmodule

>>> rtl/core/can_id_router_heartbeat_watchdog.sv
// CAN id router with heartbeat watchdog, top level.
// Frame word: result word in the next cycle; busy stays low, one word per idle cycle.
// Check word: busy through scan and closing state; one shared subtract/compare unit
// visits one device entry per cycle. A lost word waits for the next lost visit or the
// closing cycle, so the final one carries last.
// The receiver cannot stall. Reset (async, active low): devices inactive, timeout 5000.
module can_id_router_heartbeat_watchdog import canhb_pkg::*; #(
  parameter int unsigned DEVICE_COUNT   = DEVICE_COUNT_DEF,
  parameter int unsigned THRUSTER_COUNT = THRUSTER_COUNT_DEF,
  parameter int unsigned ARM_COUNT      = ARM_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                req_type_i,
  input  logic [ID_W-1:0]     frame_id_i,
  input  logic [TIME_W-1:0]   now_ms_i,
  input  logic                cfg_we_i,
  input  logic [TIME_W-1:0]   cfg_wdata_i,
  output logic                res_strobe_o,
  output logic [CLASS_W-1:0]  msg_class_o,
  output logic [UNIT_W-1:0]   unit_index_o,
  output logic                last_o
);

  localparam int unsigned IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                   state_q, state_d;
  logic [TIME_W-1:0]        timeout_q;
  logic [TIME_W-1:0]        now_q, now_d;
  logic [TIME_W-1:0]        last_seen_q [DEVICE_COUNT];
  logic [TIME_W-1:0]        last_seen_d [DEVICE_COUNT];
  logic [DEVICE_COUNT-1:0]  alive_q, alive_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     pend_q, pend_d;
  logic [IDX_W-1:0]         pend_idx_q, pend_idx_d;
  logic                     strobe_q, strobe_d;
  logic [CLASS_W-1:0]       cls_q, cls_d;
  logic [UNIT_W-1:0]        unit_q, unit_d;
  logic                     last_q, last_d;

  class_res_t               cres;
  logic [IDX_W-1:0]         hb_dev;
  logic                     accept;
  logic [TIME_W-1:0]        elapsed;
  logic                     scan_lost;
  logic [31:0]              pend_wide;

  canhb_classify #(
    .DEVICE_COUNT  (DEVICE_COUNT),
    .THRUSTER_COUNT(THRUSTER_COUNT),
    .ARM_COUNT     (ARM_COUNT),
    .IDX_W         (IDX_W)
  ) u_classify (
    .frame_id_i(frame_id_i),
    .res_o     (cres),
    .hb_dev_o  (hb_dev)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // shared unit: wrapping subtract and compare for the entry under the pointer
  assign elapsed   = now_q - last_seen_q[idx_q];
  assign scan_lost = alive_q[idx_q] && (elapsed > timeout_q);
  assign pend_wide = 32'(pend_idx_q);

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    last_seen_d = last_seen_q;
    alive_d     = alive_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    strobe_d    = 1'b0;
    cls_d       = cls_q;
    unit_d      = unit_q;
    last_d      = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_FRAME) begin
            strobe_d = 1'b1;
            cls_d    = cres.cls;
            unit_d   = cres.unit;
            last_d   = 1'b1;
            if (cres.hb_hit) begin
              last_seen_d[hb_dev] = now_ms_i;
              alive_d[hb_dev]     = 1'b1;
            end
          end else begin
            now_d   = now_ms_i;
            idx_d   = '0;
            cnt_d   = '0;
            pend_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // a lost device is held back until the next lost visit or the closing state so the final word gets last
        if (scan_lost) begin
          alive_d[idx_q] = 1'b0;
          if (pend_q) begin
            strobe_d = 1'b1;
            cls_d    = CLS_LOST;
            unit_d   = pend_wide[UNIT_W-1:0];
            last_d   = 1'b0;
          end
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          cnt_d      = cnt_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if ((idx_q == IDX_W'(DEVICE_COUNT - 1)) ||
            (scan_lost && (cnt_q == CNT_W'(MAX_RESULTS - 1)))) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (pend_q) begin
          strobe_d = 1'b1;
          cls_d    = CLS_LOST;
          unit_d   = pend_wide[UNIT_W-1:0];
          last_d   = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      timeout_q <= TIMEOUT_RESET;
      alive_q   <= '0;
      idx_q     <= '0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      alive_q  <= alive_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    last_seen_q <= last_seen_d;
    pend_idx_q  <= pend_idx_d;
    cls_q       <= cls_d;
    unit_q      <= unit_d;
    last_q      <= last_d;
  end

  assign res_strobe_o = strobe_q;
  assign msg_class_o  = cls_q;
  assign unit_index_o = unit_q;
  assign last_o       = last_q;

  // a result word only follows a frame accept or a scan/flush cycle
  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> ($past(accept) || $past(state_q == ST_SCAN) ||
                      $past(state_q == ST_DONE)))
    else $error("result word without a cause");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("lost count above cap");

  a_lost_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_lost) |=> (pend_q && !alive_q[pend_idx_q]))
    else $error("lost device still alive");

  a_check_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_CHECK) |=> busy)
    else $error("check word did not start a scan");

endmodule
